@@ hdl/cfbi_pkg.sv @@
// Shared types, constants and helper functions of the caseless FNV-1a bucket index block.
package cfbi_pkg;

	localparam int HASH_WIDTH   = 64;
	localparam int BUCKET_WIDTH = 24;
	localparam int CHAR_WIDTH   = 8;
	localparam int CNT_WIDTH    = $clog2(HASH_WIDTH);

	// Offset basis and the FNV prime, which is 2^24 + 0x193.
	localparam logic [HASH_WIDTH-1:0] FNV_BASIS = HASH_WIDTH'(64'd2166136261);
	localparam int                    PRIME_SHIFT = 24;

	// Configuration port.
	localparam int PADDR_WIDTH = 3;
	localparam int PDATA_WIDTH = 32;
	localparam logic REG_TABLE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_DONE
	} cfbi_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic div_step;
		logic out_load;
	} cfbi_cmd_t;

	// C-locale lower-case fold: only A..Z change.
	function automatic logic [CHAR_WIDTH-1:0] fold_lower(input logic [CHAR_WIDTH-1:0] b);
		logic [CHAR_WIDTH-1:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

	// Multiply by the FNV prime modulo 2^HASH_WIDTH, as a shift plus a small constant product.
	function automatic logic [HASH_WIDTH-1:0] fnv_mul(input logic [HASH_WIDTH-1:0] x);
		logic [HASH_WIDTH-1:0] lo;
		lo = (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
		return (x << PRIME_SHIFT) + lo;
	endfunction

endpackage

@@ hdl/cfbi_in_if.sv @@
// Input channel carrying one character word per handshake.
interface cfbi_in_if;
	logic                              valid;
	logic                              ready;
	logic [cfbi_pkg::CHAR_WIDTH-1:0]   char_byte;
	logic                              has_char;
	logic                              word_end;

	modport source (output valid, output char_byte, output has_char, output word_end,
		input ready);
	modport sink (input valid, input char_byte, input has_char, input word_end,
		output ready);
endinterface

@@ hdl/cfbi_out_if.sv @@
// Output channel carrying one bucket index per handshake.
interface cfbi_out_if;
	logic                              valid;
	logic                              ready;
	logic [cfbi_pkg::BUCKET_WIDTH-1:0] bucket;

	modport source (output valid, output bucket, input ready);
	modport sink (input valid, input bucket, output ready);
endinterface

@@ hdl/cfbi_ctrl.sv @@
// Controller state machine: input acceptance, division sequencing and output register control.
module cfbi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_word_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cfbi_pkg::cfbi_cmd_t cmd
);
	import cfbi_pkg::*;

	cfbi_state_t          state_q, state_d;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 div_last;

	assign out_free = !out_valid_q || out_ready;
	assign div_last = (cnt_q == CNT_WIDTH'(HASH_WIDTH - 1));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_word_end) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// State, step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/cfbi_dpath.sv @@
// Datapath: hash accumulator, restoring divider and bucket output register.
module cfbi_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfbi_pkg::cfbi_cmd_t                 cmd,
	input  logic [cfbi_pkg::CHAR_WIDTH-1:0]     char_byte,
	input  logic                                has_char,
	input  logic                                word_end,
	input  logic [cfbi_pkg::BUCKET_WIDTH-1:0]   table_size,
	output logic [cfbi_pkg::BUCKET_WIDTH-1:0]   bucket
);
	import cfbi_pkg::*;

	logic [HASH_WIDTH-1:0]   acc_q;
	logic [HASH_WIDTH-1:0]   acc_next;
	logic [HASH_WIDTH-1:0]   dvd_q;
	logic [BUCKET_WIDTH-1:0] rem_q;
	logic [BUCKET_WIDTH:0]   trial;
	logic [BUCKET_WIDTH:0]   diff;
	logic [BUCKET_WIDTH-1:0] rem_next;
	logic [BUCKET_WIDTH-1:0] bucket_q;

	// Fold the character into the hash and multiply by the prime.
	always_comb begin
		acc_next = acc_q;
		if (has_char) begin
			acc_next = fnv_mul(acc_q ^ HASH_WIDTH'(fold_lower(char_byte)));
		end
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial    = {rem_q, dvd_q[HASH_WIDTH-1]};
		diff     = trial - {1'b0, table_size};
		rem_next = trial[BUCKET_WIDTH-1:0];
		if (!diff[BUCKET_WIDTH]) begin
			rem_next = diff[BUCKET_WIDTH-1:0];
		end
	end

	// The accumulator restarts from the basis once a word ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= FNV_BASIS;
		end else if (cmd.accept) begin
			acc_q <= word_end ? FNV_BASIS : acc_next;
		end
	end

	// Divider registers and the bucket output register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dvd_q <= acc_next;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HASH_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.out_load) begin
			bucket_q <= (table_size == '0) ? '0 : rem_q;
		end
	end

	assign bucket = bucket_q;

endmodule

@@ hdl/caseless_fnv1a_bucket_index.sv @@
// Top level of the caseless FNV-1a bucket index: configuration register and module wiring.
// A word arrives one character per input word and is hashed caselessly in a 64-bit accumulator
// with the 32-bit FNV-1a offset basis and prime, at one character per cycle while no divide runs.
// The word that ends it starts a restoring division by table_size, one quotient bit per cycle,
// so that word's bucket is loaded into the output register after 64 divide steps; the next word
// is taken only once the block is idle again, never during the divide. A bucket waiting in the
// output register does not stop the next characters, but the next ending word holds in its
// output load until that bucket is taken. table_size sits at byte address 0 of the register
// port, resets to 17, and a value of zero gives bucket 0.
module caseless_fnv1a_bucket_index (
	input  logic                                clk,
	input  logic                                arst_n,
	cfbi_in_if.sink                             chars,
	cfbi_out_if.source                          buckets,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cfbi_pkg::PADDR_WIDTH-1:0]    paddr,
	input  logic [cfbi_pkg::PDATA_WIDTH-1:0]    pwdata,
	output logic [cfbi_pkg::PDATA_WIDTH-1:0]    prdata,
	output logic                                pready
);
	import cfbi_pkg::*;

	logic [BUCKET_WIDTH-1:0] table_size_q;
	logic                    reg_sel;
	cfbi_cmd_t               cmd;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_TABLE_SIZE);

	// Register write in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= BUCKET_WIDTH'(17);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			table_size_q <= pwdata[BUCKET_WIDTH-1:0];
		end
	end

	// Register read.
	assign prdata = reg_sel ? PDATA_WIDTH'(table_size_q) : '0;

	cfbi_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (chars.valid),
		.in_word_end (chars.word_end),
		.in_ready    (chars.ready),
		.out_valid   (buckets.valid),
		.out_ready   (buckets.ready),
		.cmd         (cmd)
	);

	cfbi_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.char_byte  (chars.char_byte),
		.has_char   (chars.has_char),
		.word_end   (chars.word_end),
		.table_size (table_size_q),
		.bucket     (buckets.bucket)
	);

endmodule
